/* rtl/olist_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package olist_pkg;

	localparam int CAPACITY_DEF = 16;

	localparam int MODE_W = 3;
	localparam int VAL_W  = 32;
	localparam int POS_W  = 8;
	localparam int ST_W   = 2;
	localparam int LEN_W  = 5;

	// command modes
	localparam logic [MODE_W-1:0] MODE_INS_HEAD  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_INS_TAIL  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_INS_AFTER = 3'd2;
	localparam logic [MODE_W-1:0] MODE_READ      = 3'd3;
	localparam logic [MODE_W-1:0] MODE_DEL_TAIL  = 3'd4;
	localparam logic [MODE_W-1:0] MODE_DEL_AT    = 3'd5;

	// result status codes
	localparam logic [ST_W-1:0] ST_DONE = 2'd0;
	localparam logic [ST_W-1:0] ST_NONE = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL = 2'd2;

endpackage

`default_nettype wire

/* rtl/olist_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module olist_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire                      clk,
	input  wire                      wr_en,
	input  wire [$clog2(DEPTH)-1:0]  wr_addr,
	input  wire [WIDTH-1:0]          wr_data,
	input  wire                      rd_en,
	input  wire [$clog2(DEPTH)-1:0]  rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		// hold the last read word until the next read
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

/* rtl/ordered_list_engine_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// A read, a refused or trivial command goes from IDLE straight to FINISH; an insert passes
// through MOVE and PUT, and a delete at a position through MOVE, before FINISH.
// One command at a time: a new command is taken only in IDLE; the shift loop through the
// single-port-pair entry RAM (one entry moved per cycle) sets how long a command runs.
// Reset: arst_n clears the list count, the sequencer state and out_valid; entry contents stay undefined.
module ordered_list_engine_top
	import olist_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire                      clk,
	input  wire                      arst_n,
	// command channel
	input  wire                      in_valid,
	output logic                     in_ready,
	input  wire [MODE_W-1:0]         mode,
	input  wire signed [VAL_W-1:0]   item_value,
	input  wire [POS_W-1:0]          position,
	// result channel
	output logic                     out_valid,
	input  wire                      out_ready,
	output logic signed [VAL_W-1:0]  read_value,
	output logic [ST_W-1:0]          status,
	output logic [LEN_W-1:0]         length
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	// Sequencer: IDLE takes a command, MOVE shifts entries one per cycle through the
	// RAM, PUT stores the new value in the opened gap, FINISH loads the result word.
	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_MOVE   = 4'b0010,
		S_PUT    = 4'b0100,
		S_FINISH = 4'b1000
	} state_t;

	state_t state_q;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] moves_q;    // entry moves still to issue
	logic [IDX_W-1:0] cur_q;      // next RAM address to read in the shift loop
	logic [IDX_W-1:0] slot_q;     // insert slot
	logic             up_q;       // shift direction: 1 toward the tail (insert)
	logic             rsel_q;     // result carries the RAM read word
	logic [ST_W-1:0]  st_q;
	logic [VAL_W-1:0] val_q;

	// read issued in the previous MOVE cycle, and where its word goes
	logic             pend_s1;
	logic [IDX_W-1:0] wa_s1;

	logic             out_valid_q;
	logic [VAL_W-1:0] read_value_q;
	logic [ST_W-1:0]  status_q;
	logic [LEN_W-1:0] length_q;

	// RAM ports
	logic             ram_wr_en;
	logic [IDX_W-1:0] ram_wr_addr;
	logic [VAL_W-1:0] ram_wr_data;
	logic             ram_rd_en;
	logic [IDX_W-1:0] ram_rd_addr;
	logic [VAL_W-1:0] ram_rd_data;

	logic             accept;
	logic             issue;
	logic             full;
	logic             pos_in;
	logic [CMP_W-1:0] pos_x;
	logic [CMP_W-1:0] cnt_x;
	logic [CNT_W-1:0] pos_c;
	logic [CNT_W-1:0] ins_slot;
	logic             res_load;
	logic [LEN_W+CNT_W-1:0] len_x;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	assign pos_x  = CMP_W'(position);
	assign cnt_x  = CMP_W'(count_q);
	assign pos_in = (pos_x < cnt_x);
	assign pos_c  = CNT_W'(position);
	assign full   = (count_q >= CNT_W'(CAPACITY));

	// slot of a new value; insert-after clamps to the last element
	always_comb begin
		case (mode)
			MODE_INS_HEAD: ins_slot = '0;
			MODE_INS_TAIL: ins_slot = count_q;
			default: begin
				if (count_q == '0) begin
					ins_slot = '0;
				end else if (pos_in) begin
					ins_slot = pos_c + CNT_W'(1);
				end else begin
					ins_slot = count_q;
				end
			end
		endcase
	end

	assign issue = (state_q == S_MOVE) && (moves_q != '0);

	// read port: the command's read at accept, or the shift loop
	assign ram_rd_en   = issue || (accept && (mode == MODE_READ) && pos_in);
	assign ram_rd_addr = (state_q == S_MOVE) ? cur_q : IDX_W'(position);

	// write port: shifted word in MOVE, new value in PUT
	assign ram_wr_en   = ((state_q == S_MOVE) && pend_s1) || (state_q == S_PUT);
	assign ram_wr_addr = (state_q == S_PUT) ? slot_q : wa_s1;
	assign ram_wr_data = (state_q == S_PUT) ? val_q : ram_rd_data;

	olist_ram #(
		.WIDTH (VAL_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// load the result word once the output register is free
	assign res_load = (state_q == S_FINISH) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			moves_q <= '0;
			pend_s1 <= 1'b0;
			up_q    <= 1'b0;
			rsel_q  <= 1'b0;
			st_q    <= ST_DONE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						rsel_q  <= 1'b0;
						st_q    <= ST_DONE;
						pend_s1 <= 1'b0;
						state_q <= S_FINISH;
						case (mode)
							MODE_INS_HEAD, MODE_INS_TAIL, MODE_INS_AFTER: begin
								if (full) begin
									st_q <= ST_FULL;
								end else begin
									// move entries slot..count-1 up, last first
									up_q    <= 1'b1;
									moves_q <= count_q - ins_slot;
									state_q <= S_MOVE;
								end
							end
							MODE_READ: begin
								if (pos_in) begin
									rsel_q <= 1'b1;
								end else begin
									st_q <= ST_NONE;
								end
							end
							MODE_DEL_TAIL: begin
								if (count_q == '0) begin
									st_q <= ST_NONE;
								end else begin
									count_q <= count_q - CNT_W'(1);
								end
							end
							MODE_DEL_AT: begin
								if (pos_in) begin
									// move entries position+1..count-1 down
									up_q    <= 1'b0;
									moves_q <= count_q - CNT_W'(1) - pos_c;
									state_q <= S_MOVE;
								end else begin
									st_q <= ST_NONE;
								end
							end
							default: begin
								st_q <= ST_NONE;
							end
						endcase
					end
				end
				S_MOVE: begin
					pend_s1 <= issue;
					if (issue) begin
						moves_q <= moves_q - CNT_W'(1);
					end else if (!pend_s1) begin
						// last move written back
						if (up_q) begin
							state_q <= S_PUT;
						end else begin
							count_q <= count_q - CNT_W'(1);
							state_q <= S_FINISH;
						end
					end
				end
				S_PUT: begin
					count_q <= count_q + CNT_W'(1);
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (res_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// shift loop addresses and command payload
	always_ff @(posedge clk) begin
		if (accept) begin
			val_q  <= item_value;
			slot_q <= IDX_W'(ins_slot);
			if (mode == MODE_DEL_AT) begin
				cur_q <= IDX_W'(pos_c + CNT_W'(1));
			end else begin
				cur_q <= IDX_W'(count_q - CNT_W'(1));
			end
		end else if (issue) begin
			if (up_q) begin
				cur_q <= cur_q - IDX_W'(1);
				wa_s1 <= cur_q + IDX_W'(1);
			end else begin
				cur_q <= cur_q + IDX_W'(1);
				wa_s1 <= cur_q - IDX_W'(1);
			end
		end
	end

	// output register
	assign len_x = {LEN_W'(0), count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			read_value_q <= rsel_q ? ram_rd_data : '0;
			status_q     <= st_q;
			length_q     <= len_x[LEN_W-1:0];
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;
	assign status     = status_q;
	assign length     = length_q;

endmodule

`default_nettype wire
